>>> design/memory_write_record_framer_top_macros.svh
// Assertion macros shared by the framer checker.
`ifndef MEMORY_WRITE_RECORD_FRAMER_TOP_MACROS_SVH
`define MEMORY_WRITE_RECORD_FRAMER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MWRF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MWRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/mwrf_pkg.sv
// Shared types and record constants of the memory-write record framer.
package mwrf_pkg;

   localparam int LANES = 8;

   localparam logic [7:0] TAG_DATA   = 8'h18;
   localparam logic [7:0] TAG_COUNT  = 8'h17;
   localparam logic [7:0] COUNT_SIZE = 8'h02;
   localparam logic [7:0] TAG_ADDR   = 8'h16;
   localparam logic [7:0] ADDR_SIZE  = 8'h03;

   // Byte positions within the count and address records.
   localparam logic [3:0] BLK_TAG_COUNT  = 4'd0;
   localparam logic [3:0] BLK_COUNT_SIZE = 4'd1;
   localparam logic [3:0] BLK_COUNT_HI   = 4'd2;
   localparam logic [3:0] BLK_COUNT_MID  = 4'd3;
   localparam logic [3:0] BLK_COUNT_LO   = 4'd4;
   localparam logic [3:0] BLK_TAG_ADDR   = 4'd5;
   localparam logic [3:0] BLK_ADDR_SIZE  = 4'd6;
   localparam logic [3:0] BLK_ADDR_B3    = 4'd7;
   localparam logic [3:0] BLK_ADDR_B2    = 4'd8;
   localparam logic [3:0] BLK_ADDR_B1    = 4'd9;
   localparam logic [3:0] BLK_ADDR_B0    = 4'd10;

   typedef enum logic [1:0] {
      SRC_TAG,
      SRC_LEN,
      SRC_DATA,
      SRC_BLOCK
   } src_type;

   typedef struct packed {
      logic       ready;
      logic       push;
      src_type    src;
      logic [3:0] blk_idx;
      logic       rd_en;
      logic [7:0] rd_addr;
      logic       move;
      logic       move_last;
   } cmd_type;

   typedef struct packed {
      logic       accept;
      logic       chunk_close;
      logic       block_done;
      logic       pk_full;
      logic       out_free;
      logic [7:0] last_idx;
   } status_type;

endpackage

>>> design/mwrf_req_if.sv
// Input byte channel of the framer.
interface mwrf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, data_byte, end_of_stream, input ready);
   modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

>>> design/mwrf_rsp_if.sv
// Packed result channel of the framer.
interface mwrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] lane0;
   logic [7:0] lane1;
   logic [7:0] lane2;
   logic [7:0] lane3;
   logic [7:0] lane4;
   logic [7:0] lane5;
   logic [7:0] lane6;
   logic [7:0] lane7;
   logic [3:0] valid_bytes;
   logic       last_of_run;

   modport source (output valid, lane0, lane1, lane2, lane3, lane4, lane5, lane6, lane7,
                   valid_bytes, last_of_run, input ready);
   modport sink (input valid, lane0, lane1, lane2, lane3, lane4, lane5, lane6, lane7,
                 valid_bytes, last_of_run, output ready);
endinterface

>>> design/mwrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mwrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/mwrf_ctrl.sv
// Sequencer that walks the chunk and block records one byte at a time.
module mwrf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  mwrf_pkg::status_type status,
   output mwrf_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAG,
      ST_LEN,
      ST_DATA,
      ST_BLOCK,
      ST_FLUSH
   } state_type;

   state_type  state_ff, state_in;
   logic [7:0] idx_ff, idx_in;
   logic       blk_ff, blk_in;
   logic       adv;

   assign adv = !status.pk_full;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      blk_in        = blk_ff;
      cmd.ready     = (state_ff == ST_IDLE);
      cmd.push      = 1'b0;
      cmd.src       = mwrf_pkg::SRC_TAG;
      cmd.blk_idx   = idx_ff[3:0];
      cmd.rd_en     = 1'b0;
      cmd.rd_addr   = idx_ff + 8'd1;
      cmd.move      = 1'b0;
      cmd.move_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (status.accept && status.chunk_close) begin
               state_in = ST_TAG;
               blk_in   = status.block_done;
            end
         end
         ST_TAG: begin
            cmd.src  = mwrf_pkg::SRC_TAG;
            cmd.push = adv;
            cmd.move = status.pk_full && status.out_free;
            if (adv) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            cmd.src     = mwrf_pkg::SRC_LEN;
            cmd.push    = adv;
            cmd.move    = status.pk_full && status.out_free;
            cmd.rd_addr = 8'd0;
            if (adv) begin
               // prefetch the first data byte
               cmd.rd_en = 1'b1;
               idx_in    = 8'd0;
               state_in  = ST_DATA;
            end
         end
         ST_DATA: begin
            cmd.src  = mwrf_pkg::SRC_DATA;
            cmd.push = adv;
            cmd.move = status.pk_full && status.out_free;
            if (adv) begin
               if (idx_ff == status.last_idx) begin
                  idx_in   = 8'd0;
                  state_in = blk_ff ? ST_BLOCK : ST_FLUSH;
               end else begin
                  cmd.rd_en = 1'b1;
                  idx_in    = idx_ff + 8'd1;
               end
            end
         end
         ST_BLOCK: begin
            cmd.src  = mwrf_pkg::SRC_BLOCK;
            cmd.push = adv;
            cmd.move = status.pk_full && status.out_free;
            if (adv) begin
               if (idx_ff[3:0] == mwrf_pkg::BLK_ADDR_B0) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + 8'd1;
               end
            end
         end
         ST_FLUSH: begin
            cmd.move      = status.out_free;
            cmd.move_last = 1'b1;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= 8'd0;
         blk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         blk_ff   <= blk_in;
      end
   end

endmodule

>>> design/mwrf_dp.sv
// Datapath: chunk RAM, fill counters, address, byte packer and result register.
module mwrf_dp #(
   parameter int CHUNK_BYTES = 256,
   parameter int MAX_BLOCK   = 8192,
   parameter int OUT_LANES   = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   mwrf_req_if.sink             req_bus,
   mwrf_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [13:0]          csr_wdata,
   input  mwrf_pkg::cmd_type     cmd,
   output mwrf_pkg::status_type  status
);

   localparam int CW   = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
   localparam int BW   = $clog2(MAX_BLOCK + 1);
   localparam int CMPW = (BW > 14) ? BW + 1 : 15;
   localparam int BS_RESET_I  = MAX_BLOCK % 16384;
   localparam int EFF_RESET_I = (BS_RESET_I == 0) ? 1 :
                                ((BS_RESET_I > MAX_BLOCK) ? MAX_BLOCK : BS_RESET_I);
   localparam logic [BW-1:0]   EFF_RESET  = BW'(EFF_RESET_I);
   localparam logic [CW-1:0]   CHUNK_LAST = CW'(CHUNK_BYTES - 1);
   localparam logic [CMPW-1:0] MAX_CMP    = CMPW'(MAX_BLOCK);
   localparam logic [3:0]      LANES_CNT  = 4'(OUT_LANES);
   localparam int              LW         = $clog2(mwrf_pkg::LANES);

   logic [BW-1:0]   eff_ff, eff_in;
   logic [CW-1:0]   cf_ff, cf_in;
   logic [BW-1:0]   bf_ff, bf_in;
   logic [31:0]     addr_ff, addr_in;
   logic [7:0]      len_ff;
   logic [23:0]     cnt_ff;
   logic [31:0]     start_ff;

   logic [7:0]      pk_ff [mwrf_pkg::LANES];
   logic [7:0]      pk_in [mwrf_pkg::LANES];
   logic [3:0]      pk_cnt_ff, pk_cnt_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_lane_ff [mwrf_pkg::LANES];
   logic [3:0]      rsp_cnt_ff;
   logic            rsp_last_ff;

   logic            accept;
   logic [BW-1:0]   bf_inc;
   logic            block_done;
   logic            chunk_close;
   logic [CMPW-1:0] wd_ext;
   logic [7:0]      rd_data;
   logic [7:0]      blk_byte;
   logic [7:0]      emit_byte;
   logic            pk_full;
   logic            out_free;

   // Configuration: hold the block size already clamped to its usable range.
   assign wd_ext = CMPW'(csr_wdata);

   always_comb begin
      eff_in = eff_ff;
      if (csr_we) begin
         if (csr_wdata == 14'd0) begin
            eff_in = BW'(1);
         end else if (wd_ext > MAX_CMP) begin
            eff_in = BW'(MAX_BLOCK);
         end else begin
            eff_in = BW'(wd_ext);
         end
      end
   end

   assign accept      = req_bus.valid && cmd.ready;
   assign req_bus.ready = cmd.ready;
   assign bf_inc      = bf_ff + BW'(1);
   assign block_done  = req_bus.end_of_stream || (bf_inc >= eff_ff);
   assign chunk_close = (cf_ff == CHUNK_LAST) || block_done;

   always_comb begin
      cf_in   = cf_ff;
      bf_in   = bf_ff;
      addr_in = addr_ff;
      if (accept) begin
         cf_in = chunk_close ? '0 : cf_ff + CW'(1);
         if (block_done) begin
            bf_in   = '0;
            addr_in = req_bus.end_of_stream ? 32'd0 : addr_ff + 32'(bf_inc);
         end else begin
            bf_in = bf_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_ff  <= EFF_RESET;
         cf_ff   <= '0;
         bf_ff   <= '0;
         addr_ff <= 32'd0;
      end else begin
         eff_ff  <= eff_in;
         cf_ff   <= cf_in;
         bf_ff   <= bf_in;
         addr_ff <= addr_in;
      end
   end

   // Snapshot the record fields of the accepted byte.
   always_ff @(posedge clock) begin
      if (accept) begin
         len_ff   <= 8'(cf_ff);
         cnt_ff   <= 24'(bf_ff);
         start_ff <= addr_ff;
      end
   end

   mwrf_ram #(
      .WIDTH (8),
      .DEPTH (CHUNK_BYTES)
   ) u_chunk_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (cf_ff),
      .wr_data (req_bus.data_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr[CW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      case (cmd.blk_idx)
         mwrf_pkg::BLK_TAG_COUNT:  blk_byte = mwrf_pkg::TAG_COUNT;
         mwrf_pkg::BLK_COUNT_SIZE: blk_byte = mwrf_pkg::COUNT_SIZE;
         mwrf_pkg::BLK_COUNT_HI:   blk_byte = cnt_ff[23:16];
         mwrf_pkg::BLK_COUNT_MID:  blk_byte = cnt_ff[15:8];
         mwrf_pkg::BLK_COUNT_LO:   blk_byte = cnt_ff[7:0];
         mwrf_pkg::BLK_TAG_ADDR:   blk_byte = mwrf_pkg::TAG_ADDR;
         mwrf_pkg::BLK_ADDR_SIZE:  blk_byte = mwrf_pkg::ADDR_SIZE;
         mwrf_pkg::BLK_ADDR_B3:    blk_byte = start_ff[31:24];
         mwrf_pkg::BLK_ADDR_B2:    blk_byte = start_ff[23:16];
         mwrf_pkg::BLK_ADDR_B1:    blk_byte = start_ff[15:8];
         mwrf_pkg::BLK_ADDR_B0:    blk_byte = start_ff[7:0];
         default:                  blk_byte = 8'd0;
      endcase
   end

   always_comb begin
      case (cmd.src)
         mwrf_pkg::SRC_TAG:   emit_byte = mwrf_pkg::TAG_DATA;
         mwrf_pkg::SRC_LEN:   emit_byte = len_ff;
         mwrf_pkg::SRC_DATA:  emit_byte = rd_data;
         mwrf_pkg::SRC_BLOCK: emit_byte = blk_byte;
         default:             emit_byte = 8'd0;
      endcase
   end

   // Packer: gather bytes into lanes, clear all lanes when the word moves out.
   assign pk_full  = (pk_cnt_ff == LANES_CNT);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      pk_in     = pk_ff;
      pk_cnt_in = pk_cnt_ff;
      if (cmd.move) begin
         for (int i = 0; i < mwrf_pkg::LANES; i++) begin
            pk_in[i] = 8'd0;
         end
         pk_cnt_in = 4'd0;
      end else if (cmd.push) begin
         pk_in[pk_cnt_ff[LW-1:0]] = emit_byte;
         pk_cnt_in                = pk_cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mwrf_pkg::LANES; i++) begin
            pk_ff[i] <= 8'd0;
         end
         pk_cnt_ff <= 4'd0;
      end else begin
         pk_ff     <= pk_in;
         pk_cnt_ff <= pk_cnt_in;
      end
   end

   // Result register: load on move, drop valid once the transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.move) begin
         rsp_lane_ff <= pk_ff;
         rsp_cnt_ff  <= pk_cnt_ff;
         rsp_last_ff <= cmd.move_last;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.lane0       = rsp_lane_ff[0];
   assign rsp_bus.lane1       = rsp_lane_ff[1];
   assign rsp_bus.lane2       = rsp_lane_ff[2];
   assign rsp_bus.lane3       = rsp_lane_ff[3];
   assign rsp_bus.lane4       = rsp_lane_ff[4];
   assign rsp_bus.lane5       = rsp_lane_ff[5];
   assign rsp_bus.lane6       = rsp_lane_ff[6];
   assign rsp_bus.lane7       = rsp_lane_ff[7];
   assign rsp_bus.valid_bytes = rsp_cnt_ff;
   assign rsp_bus.last_of_run = rsp_last_ff;

   assign status.accept      = accept;
   assign status.chunk_close = chunk_close;
   assign status.block_done  = block_done;
   assign status.pk_full     = pk_full;
   assign status.out_free    = out_free;
   assign status.last_idx    = len_ff;

endmodule

>>> design/memory_write_record_framer_top.sv
// Memory-write record framer. Raw bytes enter on req_bus, one per transfer, and
// are stored in a chunk RAM. A byte that closes a chunk (chunk full, block full
// or end of stream) starts a run: tag 0x18, length - 1 and the chunk data, and,
// when the block closes, the count record (0x17 0x02 + 24-bit count - 1) and the
// address record (0x16 0x03 + 32-bit start address). The run leaves on rsp_bus
// packed OUT_LANES bytes per transfer, last_of_run set on its final transfer.
// A byte that closes nothing leaves req_bus.ready high. A run keeps req_bus.ready
// low from the accepting edge until its last word has moved out: the chunk RAM has
// one read port, the sequencer emits one byte per cycle while the packer has room,
// and moving each packed word out, the last one included, is a step of its own;
// rsp_bus back-pressure holds the run longer. csr_wdata
// written with csr_we sets the block size (0 acts as 1, above MAX_BLOCK clamps).
// End of stream clears the fill counts and the address; the block size is kept.
module memory_write_record_framer_top #(
   parameter int CHUNK_BYTES = 256,
   parameter int MAX_BLOCK   = 8192,
   parameter int OUT_LANES   = 8
) (
   input  logic        clock,
   input  logic        reset,
   mwrf_req_if.sink    req_bus,
   mwrf_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic [13:0] csr_wdata
);

   mwrf_pkg::cmd_type    cmd;
   mwrf_pkg::status_type status;

   mwrf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   mwrf_dp #(
      .CHUNK_BYTES (CHUNK_BYTES),
      .MAX_BLOCK   (MAX_BLOCK),
      .OUT_LANES   (OUT_LANES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

>>> design/mwrf_checker.sv
// Port-level checker of the framer and its bind to the top level.
`include "memory_write_record_framer_top_macros.svh"

module mwrf_checker #(
   parameter int OUT_LANES = 8
) (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] valid_bytes,
   input logic       last_of_run
);

   localparam logic [3:0] LANES_CNT = 4'(OUT_LANES);

   `MWRF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `MWRF_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(valid_bytes) && $stable(last_of_run), "result changed while stalled")
   `MWRF_ASSERT_SAME(a_count_range, rsp_valid, valid_bytes != 4'd0 && valid_bytes <= LANES_CNT, "byte count out of range")
   `MWRF_ASSERT_SAME(a_partial_last, rsp_valid && valid_bytes != LANES_CNT, last_of_run, "partial word before end of run")
   `MWRF_ASSERT_SAME(a_run_busy, rsp_valid && !last_of_run, !req_ready, "input taken in the middle of a run")

endmodule

bind memory_write_record_framer_top mwrf_checker #(
   .OUT_LANES (OUT_LANES)
) u_mwrf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .valid_bytes (rsp_bus.valid_bytes),
   .last_of_run (rsp_bus.last_of_run)
);

>>> tb/tb_top.sv
// Self-checking testbench for the memory-write record framer: byte stream in, packed records out.
`timescale 1ns / 100ps

module tb_top;

   localparam int CHUNK_BYTES   = 256;
   localparam int MAX_BLOCK     = 8192;
   localparam int RANDOM_ITEMS  = 350;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int IDLE_PCT      = 17;

   typedef struct packed {
      logic [7:0] data;
      logic       eos;
   } stream_byte_type;

   typedef struct packed {
      logic [7:0][7:0] lanes;
      logic [3:0]      count;
      logic            last;
   } framed_word_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [13:0] csr_wdata;

   mwrf_req_if req_bus ();
   mwrf_rsp_if rsp_bus ();

   memory_write_record_framer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [7:0]  held [CHUNK_BYTES];
   int          held_count = 0;
   int          block_bytes = 0;
   logic [31:0] base_addr = '0;
   logic [13:0] size_reg = 14'(MAX_BLOCK);

   stream_byte_type stream_bytes [$];
   framed_word_type framed_words [$];

   int  queued = 0;
   int  accepted = 0;
   int  words_checked = 0;
   int  errors = 0;
   int  settings = 0;
   int  cycle_count = 0;
   bit  req_took = 1'b0;
   bit  calm = 1'b0;
   int  hold_asked = 0;
   int  hold_taken = 0;
   int  hold_left = 0;

   framed_word_type got;
   framed_word_type want;
   stream_byte_type cur;

   // Frame one accepted byte and queue the packed words it should produce.
   function automatic void frame_byte(input logic [7:0] b, input logic eos);
      logic [7:0]      run [$];
      int              span;
      bit              done;
      logic [23:0]     count;
      framed_word_type w;
      int              words;
      int              left;
      held[held_count] = b;
      held_count++;
      block_bytes++;
      span = (size_reg == 0) ? 1 : (size_reg > MAX_BLOCK) ? MAX_BLOCK : int'(size_reg);
      done = eos || block_bytes >= span;
      if (held_count >= CHUNK_BYTES || done) begin
         run.push_back(mwrf_pkg::TAG_DATA);
         run.push_back(8'(held_count - 1));
         for (int i = 0; i < held_count; i++) run.push_back(held[i]);
         held_count = 0;
      end
      if (done) begin
         count = 24'(block_bytes - 1);
         run.push_back(mwrf_pkg::TAG_COUNT);
         run.push_back(mwrf_pkg::COUNT_SIZE);
         run.push_back(count[23:16]);
         run.push_back(count[15:8]);
         run.push_back(count[7:0]);
         run.push_back(mwrf_pkg::TAG_ADDR);
         run.push_back(mwrf_pkg::ADDR_SIZE);
         run.push_back(base_addr[31:24]);
         run.push_back(base_addr[23:16]);
         run.push_back(base_addr[15:8]);
         run.push_back(base_addr[7:0]);
         base_addr = base_addr + 32'(block_bytes);
         block_bytes = 0;
         if (eos) base_addr = '0;
      end
      words = (run.size() + mwrf_pkg::LANES - 1) / mwrf_pkg::LANES;
      for (int k = 0; k < words; k++) begin
         left = run.size() - k * mwrf_pkg::LANES;
         for (int j = 0; j < mwrf_pkg::LANES; j++)
            w.lanes[j] = (j < left) ? run[k * mwrf_pkg::LANES + j] : 8'h00;
         w.count = 4'((left < mwrf_pkg::LANES) ? left : mwrf_pkg::LANES);
         w.last = (k == words - 1);
         framed_words.push_back(w);
      end
   endfunction

   function automatic void queue_byte(input logic [7:0] b, input logic eos);
      stream_bytes.push_back('{data: b, eos: eos});
      queued++;
   endfunction

   // Wait until every byte is taken and every word has arrived, then let the block go quiet.
   task automatic settle();
      do @(negedge clock); while (accepted != queued || framed_words.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_block_size(input logic [13:0] value);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      size_reg = value;
      settings++;
   endtask

   // byte driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.data_byte <= '0;
         req_bus.end_of_stream <= 1'b0;
      end else if (!req_bus.valid || req_took) begin
         if (stream_bytes.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            cur = stream_bytes.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.data_byte <= cur.data;
            req_bus.end_of_stream <= cur.eos;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result receiver, with a single long hold-off
   always @(negedge clock) begin
      if (hold_taken != hold_asked) begin
         hold_left = HOLD_CYCLES;
         hold_taken = hold_asked;
      end
      if (hold_left > 0) hold_left--;
      rsp_bus.ready <= !reset && hold_left == 0 && (calm || $urandom_range(99) >= IDLE_PCT);
   end

   // monitor: predict on each byte transfer, check each word transfer
   always @(posedge clock) begin
      cycle_count++;
      req_took = !reset && req_bus.valid && req_bus.ready;
      if (req_took) begin
         accepted++;
         frame_byte(req_bus.data_byte, req_bus.end_of_stream);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.lanes = {rsp_bus.lane7, rsp_bus.lane6, rsp_bus.lane5, rsp_bus.lane4,
                      rsp_bus.lane3, rsp_bus.lane2, rsp_bus.lane1, rsp_bus.lane0};
         got.count = rsp_bus.valid_bytes;
         got.last = rsp_bus.last_of_run;
         if (framed_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
         end else begin
            want = framed_words.pop_front();
            words_checked++;
            for (int j = 0; j < mwrf_pkg::LANES; j++)
               if (got.lanes[j] !== want.lanes[j]) begin
                  errors++;
                  $display("%0t: lane%0d expected %02h actual %02h",
                           $time, j, want.lanes[j], got.lanes[j]);
               end
            if (got.count !== want.count) begin
               errors++;
               $display("%0t: valid_bytes expected %0d actual %0d",
                        $time, want.count, got.count);
            end
            if (got.last !== want.last) begin
               errors++;
               $display("%0t: last_of_run expected %0b actual %0b",
                        $time, want.last, got.last);
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d bytes untaken and %0d words outstanding",
                  $time, queued - accepted, framed_words.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int sizes [10] = '{1, 0, 2, 5, 8, 300, 9, 13, 64, 256};
      int random_items;
      int phase;
      int n;
      int odds;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short stream at the reset block size, then a one-byte stream
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hff, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h7f, 1'b1);
      queue_byte(8'ha5, 1'b1);

      // zero block size acts as one: every byte closes a block
      set_block_size(14'd0);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'hfe, 1'b0);

      // shrink the block size below the current fill mid-block
      set_block_size(14'(MAX_BLOCK));
      repeat (10) queue_byte(8'($urandom_range(255)), 1'b0);
      set_block_size(14'd4);
      queue_byte(8'h3c, 1'b0);
      queue_byte(8'hc3, 1'b0);
      queue_byte(8'h5a, 1'b0);
      queue_byte(8'ha5, 1'b1);

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         set_block_size(14'(sizes[phase % 10]));
         calm = (sizes[phase % 10] == 300);
         if (phase == 0) hold_asked++;
         n = (sizes[phase % 10] >= CHUNK_BYTES) ? 270 : $urandom_range(10, 30);
         if (phase == 0) n = 40;
         odds = (sizes[phase % 10] >= CHUNK_BYTES) ? 250 : 10;
         repeat (n) queue_byte(8'($urandom_range(255)), $urandom_range(odds - 1) == 0);
         random_items += n;
         phase++;
      end
      queue_byte(8'($urandom_range(255)), 1'b1);
      calm = 1'b0;

      // oversized setting acts as the largest block: a short stream ends before it fills
      set_block_size(14'h3fff);
      repeat (12) queue_byte(8'($urandom_range(255)), 1'b0);
      queue_byte(8'($urandom_range(255)), 1'b1);

      settle();
      $display("covered %0d bytes in %0d block size settings, %0d packed words checked",
               accepted, settings, words_checked);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/mwrf_pkg.sv
design/mwrf_req_if.sv
design/mwrf_rsp_if.sv
design/mwrf_ram.sv
design/mwrf_ctrl.sv
design/mwrf_dp.sv
design/memory_write_record_framer_top.sv
design/mwrf_checker.sv
tb/tb_top.sv
